### sv/ffea_pkg.sv
// shared types and codes for the first-fit extent allocator
package ffea_pkg;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_NOENTRY = 2'd2,
        ST_ZERO    = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } mode_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_WALK_RD,
        S_WALK_EV,
        S_MRG_RD,
        S_MRG_EV,
        S_NEW,
        S_DONE
    } fsm_t;

endpackage

### sv/ffea_pool.sv
// extent pool memory: start, length and link words, one write and one read port
module ffea_pool
    import ffea_pkg::*;
#(
    parameter int N  = 64,
    parameter int AW = 32,
    parameter int IW = 6
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_idx,
    input  logic [AW-1:0] wr_start,
    input  logic [AW-1:0] wr_len,
    input  logic [IW:0]   wr_link,
    input  logic [IW-1:0] rd_idx,
    output logic [AW-1:0] rd_start,
    output logic [AW-1:0] rd_len,
    output logic [IW:0]   rd_link
);

    logic [2*AW+IW:0] mem [N];
    logic [2*AW+IW:0] rd_word_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= {wr_start, wr_len, wr_link};
        end
        rd_word_reg <= mem[rd_idx];
    end

    assign rd_start = rd_word_reg[2*AW+IW:AW+IW+1];
    assign rd_len   = rd_word_reg[AW+IW:IW+1];
    assign rd_link  = rd_word_reg[IW:0];

endmodule

### sv/first_fit_extent_allocator_core.sv
// top level of the first-fit extent allocator with coalescing
// each list entry walked passes a read state and an evaluate state; a merge adds a read
// state and an evaluate state for the following extent, and a free that needs a new entry
// adds a scan for an unused one (a free of zero bytes strobes on the very next cycle)
// one word at a time: busy stays high from the accepting edge through the strobe cycle,
// so the next word is taken after the strobe at the earliest
// reset and each managed_size write run a clearing pass over all MAX_EXTENTS entries; no stall
module first_fit_extent_allocator_core
    import ffea_pkg::*;
#(
    parameter int MAX_EXTENTS = 64,
    parameter int ADDR_BITS   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [31:0] block_size,
    input  logic [31:0] block_offset,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] granted_offset,
    output logic [31:0] free_total,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int AW = ADDR_BITS;
    localparam logic [IW:0] NIL = (IW+1)'(MAX_EXTENTS);

    // widen or trim a 32-bit port value to the address width
    function automatic logic [AW-1:0] to_aw(input logic [31:0] v);
        logic [AW+31:0] t;
        t = {{AW{1'b0}}, v};
        return t[AW-1:0];
    endfunction

    function automatic logic [31:0] to_32(input logic [AW-1:0] v);
        logic [AW+31:0] t;
        t = {32'd0, v};
        return t[31:0];
    endfunction

    fsm_t state_reg, state_next;
    fsm_t dp_state;

    logic [AW-1:0] msize_reg;
    logic [AW-1:0] free_sum_reg, free_sum_next;
    logic [IW:0]   head_reg, head_next;
    logic [MAX_EXTENTS-1:0] used_reg, used_next;

    logic          mode_reg;
    logic [AW-1:0] size_reg, off_reg;
    logic [IW:0]   cur_reg, cur_next, prev_reg, prev_next;
    logic [IW:0]   steps_reg, steps_next;
    logic [IW:0]   scan_reg, scan_next;
    logic [IW:0]   nx_reg, nx_next;
    logic [AW-1:0] cs_reg, cs_next, cl_reg, cl_next;   // current extent after edit
    logic [1:0]    stat_reg, stat_next;
    logic [AW-1:0] gnt_reg, gnt_next;
    logic          tail_reg, tail_next;                // new extent goes after prev, as the list tail

    // pool ports
    logic          wr_en;
    logic [IW-1:0] wr_idx, rd_idx;
    logic [AW-1:0] wr_start, wr_len, rd_start, rd_len;
    logic [IW:0]   wr_link, rd_link;

    ffea_pool #(.N(MAX_EXTENTS), .AW(AW), .IW(IW)) u_pool (
        .clk(clk), .wr_en(wr_en), .wr_idx(wr_idx), .wr_start(wr_start),
        .wr_len(wr_len), .wr_link(wr_link), .rd_idx(rd_idx),
        .rd_start(rd_start), .rd_len(rd_len), .rd_link(rd_link)
    );

    // second write (link of prev) is folded into a pending slot
    logic          pend_reg, pend_next;
    logic [IW-1:0] pidx_reg, pidx_next;
    logic [AW-1:0] ps_reg, ps_next, pl_reg, pl_next;
    logic [IW:0]   plk_reg, plk_next;
    // prev extent contents, kept so its link can be rewritten whole
    logic [AW-1:0] pvs_reg, pvs_next, pvl_reg, pvl_next;

    logic [AW-1:0] end_cur;
    assign end_cur = rd_start + rd_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            msize_reg    <= to_aw(32'd65536);
            free_sum_reg <= to_aw(32'd65536);
            head_reg     <= '0;
            used_reg     <= '0;
            scan_reg     <= '0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            free_sum_reg <= free_sum_next;
            head_reg     <= head_next;
            used_reg     <= used_next;
            scan_reg     <= scan_next;
            pend_reg     <= pend_next;
            if (cfg_valid && cfg_ready)
            begin
                msize_reg <= to_aw(cfg_data);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            mode_reg <= mode;
            size_reg <= to_aw(block_size);
            off_reg  <= to_aw(block_offset);
        end
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        steps_reg <= steps_next;
        nx_reg    <= nx_next;
        cs_reg    <= cs_next;
        cl_reg    <= cl_next;
        stat_reg  <= stat_next;
        gnt_reg   <= gnt_next;
        tail_reg  <= tail_next;
        pidx_reg  <= pidx_next;
        ps_reg    <= ps_next;
        pl_reg    <= pl_next;
        plk_reg   <= plk_next;
        pvs_reg   <= pvs_next;
        pvl_reg   <= pvl_next;
    end

    // next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:   if (scan_reg == (IW+1)'(MAX_EXTENTS - 1)) state_next = S_IDLE;
            S_IDLE:
            begin
                if (cfg_valid) state_next = S_CLEAR;
                else if (start)
                begin
                    if (mode == MODE_FREE && block_size == 32'd0) state_next = S_DONE;
                    else state_next = S_WALK_RD;
                end
            end
            default:   state_next = state_reg;
        endcase
        // datapath states drive their own next state below
        if (state_reg != S_CLEAR && state_reg != S_IDLE) state_next = dp_state;
    end

    // datapath and outputs of the sequencer
    always_comb
    begin
        dp_state      = state_reg;
        free_sum_next = free_sum_reg;
        head_next     = head_reg;
        used_next     = used_reg;
        scan_next     = scan_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        steps_next    = steps_reg;
        nx_next       = nx_reg;
        cs_next       = cs_reg;
        cl_next       = cl_reg;
        stat_next     = stat_reg;
        gnt_next      = gnt_reg;
        tail_next     = tail_reg;
        pend_next     = pend_reg;
        pidx_next     = pidx_reg;
        ps_next       = ps_reg;
        pl_next       = pl_reg;
        plk_next      = plk_reg;
        pvs_next      = pvs_reg;
        pvl_next      = pvl_reg;
        wr_en         = 1'b0;
        wr_idx        = '0;
        wr_start      = '0;
        wr_len        = '0;
        wr_link       = NIL;
        rd_idx        = cur_reg[IW-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                used_next[scan_reg[IW-1:0]] = 1'b0;
                scan_next = scan_reg + 1'b1;
                if (scan_reg == (IW+1)'(MAX_EXTENTS - 1))
                begin
                    scan_next     = '0;
                    free_sum_next = msize_reg;
                    if (msize_reg != '0)
                    begin
                        used_next[0] = 1'b1;
                        head_next    = '0;
                        wr_en        = 1'b1;
                        wr_idx       = '0;
                        wr_len       = msize_reg;
                        wr_link      = NIL;
                    end
                    else
                    begin
                        head_next = NIL;
                    end
                end
            end
            S_IDLE:
            begin
                scan_next = '0;
                if (cfg_valid)
                begin
                    scan_next = '0;
                end
                else if (start)
                begin
                    cur_next   = head_reg;
                    prev_next  = NIL;
                    steps_next = '0;
                    pend_next  = 1'b0;
                    gnt_next   = '0;
                    stat_next  = (mode == MODE_ALLOC) ? ST_NOFIT : ST_ZERO;
                end
            end
            S_WALK_RD:
            begin
                // memory read issued for cur
                if (cur_reg == NIL || steps_reg == (IW+1)'(MAX_EXTENTS))
                begin
                    if (mode_reg == MODE_ALLOC) dp_state = S_DONE;
                    else
                    begin
                        tail_next = 1'b1;
                        dp_state  = S_SCAN;
                    end
                end
                else dp_state = S_WALK_EV;
            end
            S_WALK_EV:
            begin
                dp_state = S_WALK_RD;
                if (mode_reg == MODE_ALLOC)
                begin
                    if (rd_len == size_reg)
                    begin
                        gnt_next      = rd_start;
                        stat_next     = ST_OK;
                        free_sum_next = free_sum_reg - size_reg;
                        used_next[cur_reg[IW-1:0]] = 1'b0;
                        if (prev_reg == NIL) head_next = rd_link;
                        else
                        begin
                            wr_en    = 1'b1;
                            wr_idx   = prev_reg[IW-1:0];
                            wr_start = pvs_reg;
                            wr_len   = pvl_reg;
                            wr_link  = rd_link;
                        end
                        dp_state = S_DONE;
                    end
                    else if (rd_len > size_reg)
                    begin
                        gnt_next      = rd_start;
                        stat_next     = ST_OK;
                        free_sum_next = free_sum_reg - size_reg;
                        wr_en    = 1'b1;
                        wr_idx   = cur_reg[IW-1:0];
                        wr_start = rd_start + size_reg;
                        wr_len   = rd_len - size_reg;
                        wr_link  = rd_link;
                        dp_state = S_DONE;
                    end
                end
                else
                begin
                    if (end_cur == off_reg)
                    begin
                        cs_next  = rd_start;
                        cl_next  = rd_len + size_reg;
                        nx_next  = rd_link;
                        stat_next     = ST_OK;
                        free_sum_next = free_sum_reg + size_reg;
                        dp_state = S_MRG_RD;
                    end
                    else if (rd_start > off_reg)
                    begin
                        if (off_reg + size_reg == rd_start)
                        begin
                            wr_en    = 1'b1;
                            wr_idx   = cur_reg[IW-1:0];
                            wr_start = off_reg;
                            wr_len   = rd_len + size_reg;
                            wr_link  = rd_link;
                            stat_next     = ST_OK;
                            free_sum_next = free_sum_reg + size_reg;
                            dp_state = S_DONE;
                        end
                        else
                        begin
                            tail_next = 1'b0;
                            dp_state  = S_SCAN;
                        end
                    end
                end
                if (dp_state == S_WALK_RD)
                begin
                    prev_next  = cur_reg;
                    pvs_next   = rd_start;
                    pvl_next   = rd_len;
                    cur_next   = rd_link;
                    steps_next = steps_reg + 1'b1;
                end
                scan_next = '0;
            end
            S_MRG_RD:
            begin
                rd_idx = nx_reg[IW-1:0];
                if (nx_reg == NIL)
                begin
                    wr_en    = 1'b1;
                    wr_idx   = cur_reg[IW-1:0];
                    wr_start = cs_reg;
                    wr_len   = cl_reg;
                    wr_link  = nx_reg;
                    dp_state = S_DONE;
                end
                else dp_state = S_MRG_EV;
            end
            S_MRG_EV:
            begin
                wr_en    = 1'b1;
                wr_idx   = cur_reg[IW-1:0];
                wr_start = cs_reg;
                if (cs_reg + cl_reg == rd_start)
                begin
                    wr_len  = cl_reg + rd_len;
                    wr_link = rd_link;
                    used_next[nx_reg[IW-1:0]] = 1'b0;
                end
                else
                begin
                    wr_len  = cl_reg;
                    wr_link = nx_reg;
                end
                dp_state = S_DONE;
            end
            S_SCAN:
            begin
                // one pool entry examined a cycle for the lowest unused one
                if (scan_reg == (IW+1)'(MAX_EXTENTS))
                begin
                    stat_next = ST_NOENTRY;
                    dp_state  = S_DONE;
                end
                else if (!used_reg[scan_reg[IW-1:0]])
                begin
                    dp_state = S_NEW;
                end
                else scan_next = scan_reg + 1'b1;
            end
            S_NEW:
            begin
                // new extent written; then prev relinked through the pending slot
                used_next[scan_reg[IW-1:0]] = 1'b1;
                wr_en    = 1'b1;
                wr_idx   = scan_reg[IW-1:0];
                wr_start = off_reg;
                wr_len   = size_reg;
                wr_link  = tail_reg ? NIL : cur_reg;
                stat_next     = ST_OK;
                free_sum_next = free_sum_reg + size_reg;
                if (prev_reg == NIL) head_next = scan_reg;
                else
                begin
                    pend_next = 1'b1;
                    pidx_next = prev_reg[IW-1:0];
                    ps_next   = pvs_reg;
                    pl_next   = pvl_reg;
                    plk_next  = scan_reg;
                end
                dp_state = S_DONE;
            end
            S_DONE:
            begin
                if (pend_reg)
                begin
                    wr_en    = 1'b1;
                    wr_idx   = pidx_reg;
                    wr_start = ps_reg;
                    wr_len   = pl_reg;
                    wr_link  = plk_reg;
                    pend_next = 1'b0;
                end
                scan_next = '0;
                dp_state  = S_IDLE;
            end
            default:   dp_state = S_IDLE;
        endcase
    end

    // handshake and result outputs
    always_comb
    begin
        busy           = (state_reg != S_IDLE) || cfg_valid;
        cfg_ready      = (state_reg == S_IDLE);
        done           = (state_reg == S_DONE);
        status         = stat_reg;
        granted_offset = (stat_reg == ST_OK) ? to_32(gnt_reg) : 32'd0;
        free_total     = to_32(free_sum_reg);
    end

endmodule

### tb/tb.sv
// testbench for the first-fit extent allocator with coalescing
`timescale 1ns / 100ps

module tb
    import ffea_pkg::*;
();

    localparam int POOL_DEPTH = 64;
    localparam int NIL = POOL_DEPTH;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 4 * POOL_DEPTH + 20;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        mode;
    logic [31:0] block_size;
    logic [31:0] block_offset;
    logic        done;
    logic [1:0]  status;
    logic [31:0] granted_offset;
    logic [31:0] free_total;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    first_fit_extent_allocator_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .block_size     (block_size),
        .block_offset   (block_offset),
        .done           (done),
        .status         (status),
        .granted_offset (granted_offset),
        .free_total     (free_total),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    // clock, 10 ns period
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    typedef struct packed {
        status_t     st;
        logic [31:0] granted;
        logic [31:0] total;
    } alloc_result_t;

    // predictor copy of the extent pool
    logic [31:0] pool_start [POOL_DEPTH];
    logic [31:0] pool_len   [POOL_DEPTH];
    int          pool_next  [POOL_DEPTH];
    bit          pool_used  [POOL_DEPTH];
    int          head_entry;
    logic [31:0] free_bytes;
    logic [31:0] range_size;

    alloc_result_t pending_results[$];
    int error_count;
    int words_sent;
    int results_seen;
    int cycle_count;
    int alloc_count;
    int free_count;

    // live allocations, so frees mostly give back real blocks
    logic [31:0] held_off[$];
    logic [31:0] held_len[$];

    function automatic void pool_drop(int e);
        pool_used[e]  = 1'b0;
        pool_start[e] = '0;
        pool_len[e]   = '0;
        pool_next[e]  = NIL;
    endfunction

    function automatic void pool_init(logic [31:0] sz);
        for (int i = 0; i < POOL_DEPTH; i++)
            pool_drop(i);
        if (sz != 0)
        begin
            pool_used[0] = 1'b1;
            pool_len[0]  = sz;
            head_entry   = 0;
        end
        else
            head_entry = NIL;
        free_bytes = sz;
    endfunction

    function automatic int pool_new(logic [31:0] off, logic [31:0] sz, int link);
        for (int i = 0; i < POOL_DEPTH; i++)
            if (!pool_used[i])
            begin
                pool_used[i]  = 1'b1;
                pool_start[i] = off;
                pool_len[i]   = sz;
                pool_next[i]  = link;
                return i;
            end
        return NIL;
    endfunction

    function automatic status_t first_fit_take(logic [31:0] sz, output logic [31:0] got);
        int prev;
        int cur;
        int steps;
        int nx;
        prev = NIL;
        cur = head_entry;
        steps = 0;
        got = '0;
        while (cur < POOL_DEPTH && steps < POOL_DEPTH)
        begin
            if (pool_len[cur] == sz)
            begin
                nx = pool_next[cur];
                got = pool_start[cur];
                if (prev == NIL)
                    head_entry = nx;
                else
                    pool_next[prev] = nx;
                pool_drop(cur);
                free_bytes = free_bytes - sz;
                return ST_OK;
            end
            if (pool_len[cur] > sz)
            begin
                got = pool_start[cur];
                pool_len[cur] = pool_len[cur] - sz;
                pool_start[cur] = pool_start[cur] + sz;
                free_bytes = free_bytes - sz;
                return ST_OK;
            end
            prev = cur;
            cur = pool_next[cur];
            steps++;
        end
        return ST_NOFIT;
    endfunction

    function automatic status_t coalesce_give(logic [31:0] sz, logic [31:0] off);
        int prev;
        int cur;
        int steps;
        int nx;
        int n;
        prev = NIL;
        cur = head_entry;
        steps = 0;
        if (sz == 0)
            return ST_ZERO;
        while (cur < POOL_DEPTH && steps < POOL_DEPTH)
        begin
            if (pool_start[cur] + pool_len[cur] == off)
            begin
                nx = pool_next[cur];
                pool_len[cur] = pool_len[cur] + sz;
                if (nx < POOL_DEPTH && pool_start[cur] + pool_len[cur] == pool_start[nx])
                begin
                    pool_len[cur] = pool_len[cur] + pool_len[nx];
                    pool_next[cur] = pool_next[nx];
                    pool_drop(nx);
                end
                free_bytes = free_bytes + sz;
                return ST_OK;
            end
            if (pool_start[cur] > off)
            begin
                if (off + sz == pool_start[cur])
                begin
                    pool_start[cur] = off;
                    pool_len[cur] = pool_len[cur] + sz;
                end
                else
                begin
                    n = pool_new(off, sz, cur);
                    if (n == NIL)
                        return ST_NOENTRY;
                    if (prev == NIL)
                        head_entry = n;
                    else
                        pool_next[prev] = n;
                end
                free_bytes = free_bytes + sz;
                return ST_OK;
            end
            prev = cur;
            cur = pool_next[cur];
            steps++;
        end
        n = pool_new(off, sz, NIL);
        if (n == NIL)
            return ST_NOENTRY;
        if (prev == NIL)
            head_entry = n;
        else
            pool_next[prev] = n;
        free_bytes = free_bytes + sz;
        return ST_OK;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        error_count++;
    endtask

    // send one word, then predict its result
    task automatic send_word(mode_t m, logic [31:0] sz, logic [31:0] off);
        alloc_result_t r;
        logic [31:0] got;
        start        <= 1'b1;
        mode         <= m;
        block_size   <= sz;
        block_offset <= off;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        start <= 1'b0;
        if (m == MODE_ALLOC)
        begin
            r.st = first_fit_take(sz, got);
            r.granted = (r.st == ST_OK) ? got : 32'd0;
            alloc_count++;
            if (r.st == ST_OK && sz != 0)
            begin
                held_off.push_back(got);
                held_len.push_back(sz);
            end
        end
        else
        begin
            r.st = coalesce_give(sz, off);
            r.granted = '0;
            free_count++;
        end
        r.total = free_bytes;
        pending_results.push_back(r);
        words_sent++;
        // the block is busy for at least this cycle after taking a word
        @(posedge clk);
    endtask

    // sender gap between bursts
    task automatic sender_gap();
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 12)) @(posedge clk);
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, only while idle
    task automatic write_range(logic [31:0] sz);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= sz;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        range_size = sz;
        pool_init(sz);
        held_off.delete();
        held_len.delete();
        repeat (2) @(posedge clk);
    endtask

    // result checker: strobe cannot be held off
    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("result count", results_seen, words_sent);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.st)
                    report_mismatch("status", {30'd0, status}, {30'd0, want.st});
                if (granted_offset !== want.granted)
                    report_mismatch("granted_offset", granted_offset, want.granted);
                if (free_total !== want.total)
                    report_mismatch("free_total", free_total, want.total);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    task automatic test_directed_extremes();
        send_word(MODE_ALLOC, 32'd0, 32'hFFFF_FFFF);
        send_word(MODE_ALLOC, 32'd70000, 32'd0);
        send_word(MODE_ALLOC, 32'd100, 32'd0);
        send_word(MODE_ALLOC, 32'd200, 32'd0);
        send_word(MODE_ALLOC, 32'd300, 32'd0);
        send_word(MODE_FREE, 32'd0, 32'd0);
        send_word(MODE_FREE, 32'd200, 32'd100);
        send_word(MODE_FREE, 32'd100, 32'd0);
        send_word(MODE_FREE, 32'd300, 32'd300);
        // exact fit on the only extent empties the list
        send_word(MODE_ALLOC, 32'd65536, 32'd0);
        send_word(MODE_ALLOC, 32'd0, 32'd0);
        // free into empty list, then beyond the tail, then just below an extent so they merge
        send_word(MODE_FREE, 32'd16, 32'd1000);
        send_word(MODE_FREE, 32'd16, 32'hFFFF_FFF0);
        send_word(MODE_FREE, 32'd8, 32'd992);
        send_word(MODE_FREE, 32'hFFFF_FFFF, 32'd5000);
        send_word(MODE_FREE, 32'd4, 32'd0);
    endtask

    task automatic test_zero_and_max_range();
        write_range(32'd0);
        send_word(MODE_ALLOC, 32'd0, 32'd0);
        send_word(MODE_ALLOC, 32'd1, 32'd0);
        send_word(MODE_FREE, 32'd10, 32'd20);
        write_range(32'hFFFF_FFFF);
        send_word(MODE_ALLOC, 32'h8000_0000, 32'd0);
        send_word(MODE_ALLOC, 32'h7FFF_FFFF, 32'd0);
        send_word(MODE_FREE, 32'h7FFF_FFFF, 32'h8000_0000);
        write_range(32'd1);
        send_word(MODE_ALLOC, 32'd1, 32'd0);
    endtask

    // many disjoint frees until the pool runs out of entries
    task automatic test_pool_full();
        write_range(32'd256);
        for (int i = 0; i < POOL_DEPTH + 3; i++)
        begin
            send_word(MODE_FREE, 32'd1, 32'd1000 + 4 * i);
            sender_gap();
        end
    endtask

    task automatic test_random_traffic(int count);
        int pick;
        logic [31:0] sz;
        logic [31:0] off;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                sz = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 600);
                send_word(MODE_ALLOC, sz, $urandom());
            end
            else if (pick < 85 && held_off.size() != 0)
            begin
                int k;
                k = $urandom_range(0, held_off.size() - 1);
                off = held_off[k];
                sz  = held_len[k];
                held_off.delete(k);
                held_len.delete(k);
                send_word(MODE_FREE, sz, off);
            end
            else
                send_word(MODE_FREE, $urandom_range(0, 3) == 0 ? $urandom() :
                          $urandom_range(0, 64), $urandom());
            sender_gap();
            // halfway through, wait for everything to come back
            if (i == count / 2)
                drain_results();
        end
    endtask

    initial
    begin
        error_count = 0;
        words_sent = 0;
        results_seen = 0;
        cycle_count = 0;
        alloc_count = 0;
        free_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        mode = MODE_ALLOC;
        block_size = '0;
        block_offset = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        range_size = 32'd65536;
        pool_init(range_size);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_zero_and_max_range();
        test_pool_full();
        write_range(32'd4096);
        test_random_traffic(210);
        write_range(32'd65536);
        test_random_traffic(210);
        drain_results();

        $display("covered %0d words (%0d allocate, %0d free), %0d results checked",
                 words_sent, alloc_count, free_count, results_seen);
        $display("range sizes from zero to full width, pool exhaustion and merges");
        if (error_count == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
